/* hdl/text_console_writer_assert.svh */
// Assertion macros for the text console writer checker.
// Included by bare file name; needs a clk and an arst_n in the including scope.
`ifndef TEXT_CONSOLE_WRITER_ASSERT_SVH
`define TEXT_CONSOLE_WRITER_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define TCW_ASSERT_NOW(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("text console writer: same-cycle check failed");

// Next-cycle implication, disabled during reset
`define TCW_ASSERT_NEXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("text console writer: next-cycle check failed");

`endif

/* hdl/tcw_pkg.sv */
// Package for the text console writer: screen geometry, byte codes, opcodes and
// the command/result transaction structs. No dependencies.
`timescale 1ns / 1ps

package tcw_pkg;

	// Screen geometry
	localparam int COLUMNS  = 80;
	localparam int ROWS     = 25;
	localparam int CELLS    = COLUMNS * ROWS;
	localparam int ADDR_W   = $clog2(CELLS);
	localparam int COPY_LEN = CELLS - COLUMNS;

	// Fixed field widths
	localparam int COL_W  = 7;
	localparam int ROW_W  = 5;
	localparam int POS_W  = 11;
	localparam int CELL_W = 16;

	// Byte codes and reset values
	localparam logic [7:0]        CHAR_NL     = 8'h0A;
	localparam logic [7:0]        CHAR_TAB    = 8'h09;
	localparam logic [7:0]        CHAR_ESC    = 8'hCC;
	localparam logic [7:0]        CHAR_SPACE  = 8'h20;
	localparam logic [7:0]        ATTR_RESET  = 8'h0F;
	localparam logic [CELL_W-1:0] BLANK_CELL  = 16'h0F20;

	typedef enum logic [1:0] {
		OP_PUT        = 2'd0,
		OP_SET_CURSOR = 2'd1,
		OP_SET_COLOUR = 2'd2,
		OP_READ       = 2'd3
	} tcw_op_t;

	// Command transaction
	typedef struct packed {
		tcw_op_t     opcode;
		logic [7:0]  data_byte;
		logic        last;
		logic [7:0]  new_column;
		logic [7:0]  new_row;
		logic [3:0]  background;
		logic [3:0]  foreground;
		logic [10:0] cell_address;
	} tcw_cmd_t;

	// Result transaction
	typedef struct packed {
		logic [CELL_W-1:0] cell_data;
		logic [COL_W-1:0]  cursor_column;
		logic [ROW_W-1:0]  cursor_row;
		logic [POS_W-1:0]  cursor_position;
		logic              cursor_updated;
	} tcw_result_t;

endpackage

/* hdl/tcw_screen_ram.sv */
// Screen cell store: one write port, one read port, registered read data.
// Depends on tcw_pkg for depth and cell width.
`timescale 1ns / 1ps

module tcw_screen_ram import tcw_pkg::*; (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [CELL_W-1:0] wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [CELL_W-1:0] rdata
);

	logic [CELL_W-1:0] mem [CELLS];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read port, registered
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* hdl/text_console_writer.sv */
// Text console writer top level: command decode, cursor state and the sequencer
// for tabs, scrolling and clearing. Depends on tcw_pkg and tcw_screen_ram.
`timescale 1ns / 1ps

// Channel  | Ports                  | Transaction taken when
// command  | start, busy, cmd       | start && !busy at a rising edge
// result   | done, result           | done high, held one cycle, no back-pressure
//
// After reset a clearing pass writes blank to every cell, busy high.
// Set cursor, set colour, escape, and newline and plain characters that do not scroll:
// busy stays low and the result follows on the next cycle. Tab: one space per padded cell
// (up to 8). Read cell: passes through the registered RAM read and the result register.
// A scroll copies CELLS-COLUMNS cells through the single RAM port pair, then blanks a row.
// The result is never stalled; every item returns exactly one.

module text_console_writer import tcw_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  tcw_cmd_t    cmd,
	output logic        done,
	output tcw_result_t result
);

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_TAB,
		ST_READ,
		ST_SCROLL,
		ST_BLANK
	} state_t;

	state_t             state_q;
	logic [ADDR_W-1:0]  cnt_q;
	logic [COL_W-1:0]   work_col_q;
	logic [ROW_W-1:0]   work_row_q;
	logic [COL_W-1:0]   commit_col_q;
	logic [ROW_W-1:0]   commit_row_q;
	logic [7:0]         attr_q;
	logic               esc_q;
	logic               last_q;
	logic               done_q;
	logic               upd_q;
	logic [CELL_W-1:0]  cell_data_q;
	logic               rd_vld_s1;
	logic [ADDR_W-1:0]  wr_addr_s1;

	logic               ram_we;
	logic [ADDR_W-1:0]  ram_waddr;
	logic [CELL_W-1:0]  ram_wdata;
	logic               ram_re;
	logic [ADDR_W-1:0]  ram_raddr;
	logic [CELL_W-1:0]  ram_rdata;

	logic               col_at_end;
	logic               row_at_end;
	logic [COL_W-1:0]   col_inc;
	logic [ROW_W-1:0]   row_step;
	logic               is_nl;
	logic [COL_W-1:0]   mv_col;
	logic [ROW_W-1:0]   mv_row;
	logic               mv_scroll;
	logic               fin_last;
	logic [ADDR_W-1:0]  cur_addr;
	logic               plain_put;
	logic               set_ok;

	tcw_screen_ram u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Cursor arithmetic: column/row step with wrap and scroll detection
	always_comb begin
		col_at_end = (work_col_q == COL_W'(COLUMNS - 1));
		row_at_end = (work_row_q == ROW_W'(ROWS - 1));
		col_inc    = work_col_q + 1'b1;
		row_step   = row_at_end ? work_row_q : ROW_W'(work_row_q + 1'b1);
		is_nl      = (state_q == ST_IDLE) && (cmd.data_byte == CHAR_NL);
		if (is_nl || col_at_end) begin
			mv_col    = '0;
			mv_row    = row_step;
			mv_scroll = row_at_end;
		end else begin
			mv_col    = col_inc;
			mv_row    = work_row_q;
			mv_scroll = 1'b0;
		end
		fin_last = (state_q == ST_IDLE) ? cmd.last : last_q;
		cur_addr = ADDR_W'(ADDR_W'(work_row_q) * ADDR_W'(COLUMNS) + ADDR_W'(work_col_q));
		plain_put = (cmd.opcode == OP_PUT) && !esc_q && (cmd.data_byte != CHAR_NL)
			&& (cmd.data_byte != CHAR_TAB) && (cmd.data_byte != CHAR_ESC);
		set_ok = (cmd.new_column < 8'(COLUMNS)) && (cmd.new_row < 8'(ROWS));
	end

	// RAM port steering
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = cur_addr;
		ram_wdata = {attr_q, cmd.data_byte};
		ram_re    = 1'b0;
		ram_raddr = ADDR_W'(cmd.cell_address);
		unique case (state_q)
			ST_CLEAR, ST_BLANK: begin
				ram_we    = 1'b1;
				ram_waddr = cnt_q;
				ram_wdata = BLANK_CELL;
			end
			ST_IDLE: begin
				ram_we = start && plain_put;
				ram_re = start && (cmd.opcode == OP_READ) && (32'(cmd.cell_address) < CELLS);
			end
			ST_TAB: begin
				ram_we    = 1'b1;
				ram_wdata = {attr_q, CHAR_SPACE};
			end
			ST_SCROLL: begin
				// write lands in the cycle after its read, always at a lower address
				ram_we    = rd_vld_s1;
				ram_waddr = wr_addr_s1;
				ram_wdata = ram_rdata;
				ram_re    = (cnt_q != ADDR_W'(COPY_LEN));
				ram_raddr = ADDR_W'(cnt_q + ADDR_W'(COLUMNS));
			end
			ST_READ: begin
			end
			default: begin
			end
		endcase
	end

	// Sequencer, cursor and result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLEAR;
			cnt_q        <= '0;
			work_col_q   <= '0;
			work_row_q   <= '0;
			commit_col_q <= '0;
			commit_row_q <= '0;
			attr_q       <= ATTR_RESET;
			esc_q        <= 1'b0;
			last_q       <= 1'b0;
			done_q       <= 1'b0;
			upd_q        <= 1'b0;
			cell_data_q  <= '0;
			rd_vld_s1    <= 1'b0;
			wr_addr_s1   <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_CLEAR: begin
					if (cnt_q == ADDR_W'(CELLS - 1)) begin
						state_q <= ST_IDLE;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end

				ST_IDLE: begin
					if (start) begin
						last_q      <= cmd.last;
						cell_data_q <= '0;
						upd_q       <= 1'b0;
						unique case (cmd.opcode)
							OP_PUT: begin
								if (esc_q || cmd.data_byte == CHAR_ESC) begin
									// attribute byte or escape: cursor does not move
									if (esc_q) begin
										attr_q <= cmd.data_byte;
										esc_q  <= 1'b0;
									end else begin
										esc_q <= 1'b1;
									end
									done_q <= 1'b1;
									if (cmd.last) begin
										commit_col_q <= work_col_q;
										commit_row_q <= work_row_q;
										upd_q        <= 1'b1;
									end
								end else if (cmd.data_byte == CHAR_TAB) begin
									state_q <= ST_TAB;
								end else begin
									// newline or written character
									work_col_q <= mv_col;
									work_row_q <= mv_row;
									if (mv_scroll) begin
										cnt_q     <= '0;
										rd_vld_s1 <= 1'b0;
										state_q   <= ST_SCROLL;
									end else begin
										done_q <= 1'b1;
										if (fin_last) begin
											commit_col_q <= mv_col;
											commit_row_q <= mv_row;
											upd_q        <= 1'b1;
										end
									end
								end
							end
							OP_SET_CURSOR: begin
								done_q <= 1'b1;
								if (set_ok) begin
									work_col_q   <= COL_W'(cmd.new_column);
									work_row_q   <= ROW_W'(cmd.new_row);
									commit_col_q <= COL_W'(cmd.new_column);
									commit_row_q <= ROW_W'(cmd.new_row);
									upd_q        <= 1'b1;
								end
							end
							OP_SET_COLOUR: begin
								attr_q <= {cmd.background, cmd.foreground};
								done_q <= 1'b1;
							end
							OP_READ: begin
								if (ram_re) begin
									state_q <= ST_READ;
								end else begin
									done_q <= 1'b1;
								end
							end
							default: begin
							end
						endcase
					end
				end

				ST_TAB: begin
					// one space per cycle up to the next tab stop or row end
					if (col_at_end || work_col_q[2:0] == 3'b111) begin
						work_col_q <= mv_col;
						work_row_q <= mv_row;
						if (mv_scroll) begin
							cnt_q     <= '0;
							rd_vld_s1 <= 1'b0;
							state_q   <= ST_SCROLL;
						end else begin
							done_q  <= 1'b1;
							state_q <= ST_IDLE;
							if (fin_last) begin
								commit_col_q <= mv_col;
								commit_row_q <= mv_row;
								upd_q        <= 1'b1;
							end
						end
					end else begin
						work_col_q <= col_inc;
					end
				end

				ST_READ: begin
					cell_data_q <= ram_rdata;
					done_q      <= 1'b1;
					state_q     <= ST_IDLE;
				end

				ST_SCROLL: begin
					// copy rows up; the cell count stops at the first bottom-row cell
					if (cnt_q != ADDR_W'(COPY_LEN)) begin
						rd_vld_s1  <= 1'b1;
						wr_addr_s1 <= cnt_q;
						cnt_q      <= cnt_q + 1'b1;
					end else begin
						rd_vld_s1 <= 1'b0;
						state_q   <= ST_BLANK;
					end
				end

				ST_BLANK: begin
					if (cnt_q == ADDR_W'(CELLS - 1)) begin
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
						if (last_q) begin
							commit_col_q <= work_col_q;
							commit_row_q <= work_row_q;
							upd_q        <= 1'b1;
						end
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end

				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Result drive
	assign busy = (state_q != ST_IDLE);
	assign done = done_q;
	always_comb begin
		result.cell_data       = cell_data_q;
		result.cursor_column   = commit_col_q;
		result.cursor_row      = commit_row_q;
		result.cursor_position = POS_W'(POS_W'(commit_row_q) * POS_W'(COLUMNS)
			+ POS_W'(commit_col_q));
		result.cursor_updated  = upd_q;
	end

endmodule

/* hdl/tcw_checker.sv */
// Port-level checker for the text console writer, bound to the top level.
// Depends on tcw_pkg and text_console_writer_assert.svh.
`timescale 1ns / 1ps

`include "text_console_writer_assert.svh"

module tcw_checker import tcw_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input tcw_cmd_t    cmd,
	input logic        done,
	input tcw_result_t result
);

	logic accept;
	assign accept = start && !busy;

	// a result always lands with the engine free to take the next transaction
	`TCW_ASSERT_NOW(a_done_idle, done, !busy)

	// an in-range cursor set commits and reports the new column next cycle
	`TCW_ASSERT_NEXT(a_set_cursor, accept && cmd.opcode == OP_SET_CURSOR && cmd.new_column < 8'(COLUMNS) && cmd.new_row < 8'(ROWS), done && result.cursor_updated && result.cursor_column == $past(cmd.new_column[COL_W-1:0]))

	// out-of-range reads answer zero without waiting on a RAM read
	`TCW_ASSERT_NEXT(a_read_oob, accept && cmd.opcode == OP_READ && 32'(cmd.cell_address) >= CELLS, done && result.cell_data == '0)

	// colour change answers next cycle without touching the cursor
	`TCW_ASSERT_NEXT(a_colour, accept && cmd.opcode == OP_SET_COLOUR, done && !result.cursor_updated)

	// committed cursor moves only on a transaction that reports an update
	`TCW_ASSERT_NOW(a_cursor_hold, !(done && result.cursor_updated), $stable(result.cursor_column) && $stable(result.cursor_row))

endmodule

bind text_console_writer tcw_checker u_tcw_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.cmd    (cmd),
	.done   (done),
	.result (result)
);
